// ----- hw/rtl/ejx_pkg.sv -----
// Shared types, constants and register codes for the encoder to joystick axis block.
package ejx_pkg;

   // Field widths fixed by the interface.
   localparam int COUNT_W = 16;
   localparam int TIME_W  = 32;
   localparam int POS_W   = 8;
   localparam int REM_W   = 9;
   localparam int SHIFT_W = 4;
   localparam int MSTEP_W = 7;
   localparam int IDLE_W  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Arithmetic limits.
   localparam int SHIFT_MAX = 8;
   localparam int POS_LIMIT = 127;

   // Configuration reset values.
   localparam logic [SHIFT_W-1:0] STEP_SHIFT_RESET = 4'd4;
   localparam logic [MSTEP_W-1:0] MAX_STEP_RESET   = 7'd8;
   localparam logic [IDLE_W-1:0]  IDLE_RESET       = 16'd100;

   // Output queue depth.
   localparam int FIFO_DEPTH = 4;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_STEP_SHIFT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_STEP   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IDLE       = 2'd2;

   // Input word kinds.
   localparam logic KIND_INIT   = 1'b0;
   localparam logic KIND_UPDATE = 1'b1;

   // Direction of the last movement on one axis.
   typedef enum logic [1:0] {
      DIR_NONE = 2'b00,
      DIR_UP   = 2'b01,
      DIR_DOWN = 2'b10
   } dir_type;

   // Configuration seen by each axis.
   typedef struct packed {
      logic [SHIFT_W-1:0] step_shift;
      logic [MSTEP_W-1:0] max_step;
   } axis_cfg_type;

   // Stored state of one axis.
   typedef struct packed {
      logic [COUNT_W-1:0]      prev;
      logic signed [REM_W-1:0] rem;
      dir_type                 dir;
      logic signed [POS_W-1:0] pos;
   } axis_state_type;

   // Next values computed by one axis for an update word.
   typedef struct packed {
      logic signed [POS_W-1:0] step;
      logic signed [REM_W-1:0] rem;
      dir_type                 dir;
      logic signed [POS_W-1:0] pos;
   } axis_next_type;

   // One result word.
   typedef struct packed {
      logic                    report_valid;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_x;
   } result_type;

endpackage

// ----- hw/rtl/encoder_to_joystick_axis.sv -----
// Top level of the encoder to joystick axis block: input stage, state and output queue.
// The block takes one input word per clock cycle while req_tready is high and returns one
// result word for each, through the input register and then the output queue. An accepted
// word sits in the input register, where the per-axis add, shift and clamp logic and the
// 32-bit idle compare update the state and produce the result in that same cycle; the
// result then goes into a four-entry output queue. req_tready drops only while the queue
// and the input register together hold four words, so a stalled result side holds off new
// words without loss, and a steady stream with a ready result side runs at one word per cycle.
module encoder_to_joystick_axis import ejx_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // Input channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [63:0]           req_tdata,   // counter_x[15:0], counter_y[31:16], time_ms[63:32]
   input  logic                  req_tuser,   // kind[0]
   // Result channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // pos_x[7:0], pos_y[15:8]
   output logic                  rsp_tuser,   // report_valid[0]
   // Configuration port.
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   // Configuration registers.
   logic [SHIFT_W-1:0] step_shift_ff;
   logic [MSTEP_W-1:0] max_step_ff;
   logic [IDLE_W-1:0]  idle_timeout_ff;

   // Input stage.
   logic               in_valid_ff;
   logic               in_kind_ff;
   logic [COUNT_W-1:0] in_cx_ff;
   logic [COUNT_W-1:0] in_cy_ff;
   logic [TIME_W-1:0]  in_time_ff;
   logic               req_accept;

   // Block state.
   axis_state_type          axis_x_ff, axis_x_in;
   axis_state_type          axis_y_ff, axis_y_in;
   logic [TIME_W-1:0]       move_time_ff, move_time_in;
   logic signed [POS_W-1:0] reported_x_ff, reported_x_in;
   logic signed [POS_W-1:0] reported_y_ff, reported_y_in;

   // Axis results and the word being produced.
   axis_cfg_type  axis_cfg;
   axis_next_type nxt_x;
   axis_next_type nxt_y;
   logic          moving;
   logic          idle;
   result_type    result;

   // Output queue.
   result_type         fifo_mem [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               push;
   logic               pop;

   // Configuration writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_shift_ff   <= STEP_SHIFT_RESET;
         max_step_ff     <= MAX_STEP_RESET;
         idle_timeout_ff <= IDLE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_STEP_SHIFT: step_shift_ff   <= csr_wdata[SHIFT_W-1:0];
            REG_MAX_STEP:   max_step_ff     <= csr_wdata[MSTEP_W-1:0];
            REG_IDLE:       idle_timeout_ff <= csr_wdata[IDLE_W-1:0];
            default: ;
         endcase
      end
   end

   // Accept a word while the queue has room for everything in flight.
   assign req_tready = (count_ff + CNT_W'(in_valid_ff)) < CNT_W'(FIFO_DEPTH);
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_kind_ff <= req_tuser;
         in_cx_ff   <= req_tdata[15:0];
         in_cy_ff   <= req_tdata[31:16];
         in_time_ff <= req_tdata[63:32];
      end
   end

   // Per-axis step logic.
   assign axis_cfg.step_shift = step_shift_ff;
   assign axis_cfg.max_step   = max_step_ff;

   ejx_axis u_axis_x (
      .cfg   (axis_cfg),
      .st    (axis_x_ff),
      .count (in_cx_ff),
      .nxt   (nxt_x)
   );

   ejx_axis u_axis_y (
      .cfg   (axis_cfg),
      .st    (axis_y_ff),
      .count (in_cy_ff),
      .nxt   (nxt_y)
   );

   assign moving = (nxt_x.step != '0) || (nxt_y.step != '0);
   assign idle   = (in_time_ff - move_time_ff) > {{(TIME_W-IDLE_W){1'b0}}, idle_timeout_ff};

   // State update and result for the word in the input stage.
   always_comb begin
      axis_x_in     = axis_x_ff;
      axis_y_in     = axis_y_ff;
      move_time_in  = move_time_ff;
      reported_x_in = reported_x_ff;
      reported_y_in = reported_y_ff;
      result        = '0;
      if (in_valid_ff) begin
         axis_x_in.prev = in_cx_ff;
         axis_y_in.prev = in_cy_ff;
         if (in_kind_ff == KIND_INIT) begin
            axis_x_in.pos = '0;
            axis_y_in.pos = '0;
            move_time_in  = in_time_ff;
         end else begin
            axis_x_in.rem = nxt_x.rem;
            axis_x_in.dir = nxt_x.dir;
            axis_y_in.rem = nxt_y.rem;
            axis_y_in.dir = nxt_y.dir;
            if (moving) begin
               axis_x_in.pos = nxt_x.pos;
               axis_y_in.pos = nxt_y.pos;
               move_time_in  = in_time_ff;
            end else if (idle && ((axis_x_ff.pos != '0) || (axis_y_ff.pos != '0))) begin
               // Recenter after a quiet period.
               axis_x_in.pos = '0;
               axis_y_in.pos = '0;
               move_time_in  = in_time_ff;
            end
            if ((axis_x_in.pos != reported_x_ff) || (axis_y_in.pos != reported_y_ff)) begin
               result.report_valid = 1'b1;
               reported_x_in       = axis_x_in.pos;
               reported_y_in       = axis_y_in.pos;
            end
         end
         result.pos_x = axis_x_in.pos;
         result.pos_y = axis_y_in.pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_x_ff     <= '{prev: '0, rem: '0, dir: DIR_NONE, pos: '0};
         axis_y_ff     <= '{prev: '0, rem: '0, dir: DIR_NONE, pos: '0};
         move_time_ff  <= '0;
         reported_x_ff <= '0;
         reported_y_ff <= '0;
      end else begin
         axis_x_ff     <= axis_x_in;
         axis_y_ff     <= axis_y_in;
         move_time_ff  <= move_time_in;
         reported_x_ff <= reported_x_in;
         reported_y_ff <= reported_y_in;
      end
   end

   // Output queue: every word in the input stage is pushed.
   assign push = in_valid_ff;
   assign pop  = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_ff + CNT_W'(push) - CNT_W'(pop);
      end
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {fifo_mem[rd_ptr_ff].pos_y, fifo_mem[rd_ptr_ff].pos_x};
   assign rsp_tuser  = fifo_mem[rd_ptr_ff].report_valid;

endmodule

// ----- hw/rtl/ejx_axis.sv -----
// Per-axis step computation: count difference, remainder division and clamping.
module ejx_axis import ejx_pkg::*; (
   input  axis_cfg_type       cfg,
   input  axis_state_type     st,
   input  logic [COUNT_W-1:0] count,
   output axis_next_type      nxt
);

   localparam int ACC_W = COUNT_W + 1;

   logic signed [COUNT_W-1:0] diff;
   dir_type                   new_dir;
   logic                      flip;
   logic signed [REM_W-1:0]   rem_base;
   logic signed [ACC_W-1:0]   acc;
   logic [SHIFT_W-1:0]        sh;
   logic signed [ACC_W-1:0]   bias;
   logic signed [ACC_W-1:0]   biased;
   logic signed [ACC_W-1:0]   quot;
   logic signed [ACC_W-1:0]   rem_full;
   logic signed [ACC_W-1:0]   lim;
   logic signed [ACC_W-1:0]   step_clamped;
   logic signed [POS_W:0]     pos_sum;

   // Wrapped difference and its direction.
   assign diff    = $signed(count - st.prev);
   assign new_dir = (diff == '0) ? DIR_NONE : (diff[COUNT_W-1] ? DIR_DOWN : DIR_UP);
   assign flip    = (new_dir != DIR_NONE) && (new_dir != st.dir);

   // A reversal clears the remainder before the difference is added.
   assign rem_base = flip ? '0 : st.rem;
   assign acc = {diff[COUNT_W-1], diff}
              + {{(ACC_W-REM_W){rem_base[REM_W-1]}}, rem_base};

   // Division by 2^shift truncating toward zero: bias negative values first.
   assign sh = (cfg.step_shift > SHIFT_W'(SHIFT_MAX)) ? SHIFT_W'(SHIFT_MAX)
                                                      : cfg.step_shift;
   assign bias     = acc[ACC_W-1] ? ((ACC_W'(1) << sh) - ACC_W'(1)) : '0;
   assign biased   = acc + bias;
   assign quot     = biased >>> sh;
   assign rem_full = acc - (quot <<< sh);

   // Step clamp to the largest allowed change.
   assign lim = $signed({{(ACC_W-MSTEP_W){1'b0}}, cfg.max_step});

   always_comb begin
      if (quot > lim) begin
         step_clamped = lim;
      end else if (quot < -lim) begin
         step_clamped = -lim;
      end else begin
         step_clamped = quot;
      end
   end

   // Moved position, saturated at the position limit.
   assign pos_sum = {st.pos[POS_W-1], st.pos} + {step_clamped[POS_W-1], step_clamped[POS_W-1:0]};

   always_comb begin
      nxt.step = step_clamped[POS_W-1:0];
      nxt.rem  = rem_full[REM_W-1:0];
      nxt.dir  = flip ? new_dir : st.dir;
      if (pos_sum > (POS_W+1)'(POS_LIMIT)) begin
         nxt.pos = POS_W'(POS_LIMIT);
      end else if (pos_sum < -((POS_W+1)'(POS_LIMIT))) begin
         nxt.pos = -(POS_W'(POS_LIMIT));
      end else begin
         nxt.pos = pos_sum[POS_W-1:0];
      end
   end

endmodule

// ----- hw/rtl/ejx_checker.sv -----
// Port-level checks for the encoder to joystick axis block and their binding.
module ejx_assertions (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // A stalled result word holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   // The queue is empty right after reset.
   assert property (@(posedge clock) $fell(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // Every accepted word leads to a valid result word once it has passed the input register.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> ##2 rsp_tvalid)
      else $error("accepted word produced no result");

   // Input back-pressure only comes while the output queue holds words.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with empty output queue");

   // Positions stay within the symmetric limit and never reach -128.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:0] != 8'h80) && (rsp_tdata[15:8] != 8'h80))
      else $error("position out of range");

endmodule

bind encoder_to_joystick_axis ejx_assertions u_ejx_assertions (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- test/ejx_checker.sv -----
// Checker that predicts every joystick result word and compares it with the block's output.
module ejx_checker import ejx_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [63:0]           req_tdata,   // counter_x[15:0], counter_y[31:16], time_ms[63:32]
   input  logic                  req_tuser,   // kind[0]
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [15:0]           rsp_tdata,   // pos_x[7:0], pos_y[15:8]
   input  logic                  rsp_tuser,   // report_valid[0]
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_words
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the configuration registers.
   logic [SHIFT_W-1:0] shift_cfg;
   logic [MSTEP_W-1:0] mstep_cfg;
   logic [IDLE_W-1:0]  idle_cfg;

   // Shadow copy of the per-axis state; index 0 is X, index 1 is Y.
   logic [COUNT_W-1:0]      last_count  [2];
   logic signed [POS_W-1:0] joy_pos     [2];
   logic signed [POS_W-1:0] sent_pos    [2];
   logic signed [REM_W-1:0] frac_counts [2];
   dir_type                 last_dir    [2];
   logic [TIME_W-1:0]       last_move_ms;

   // Predicted result words, oldest first.
   result_type position_q [$];

   initial begin
      fail_count = 0;
      pending_words = 0;
   end

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string what, input int got_val, input int want_val);
      $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got_val, want_val);
      fail_count++;
   endtask

   // Accumulates one axis difference into its remainder and returns the clamped step.
   function automatic int axis_step(input int axis, input int diff);
      int      sh;
      int      span;
      int      acc;
      int      step;
      dir_type heading;
      sh = (shift_cfg > SHIFT_MAX) ? SHIFT_MAX : int'(shift_cfg);
      span = 1 << sh;
      heading = (diff > 0) ? DIR_UP : ((diff < 0) ? DIR_DOWN : DIR_NONE);
      // A reversal throws away the counts gathered in the old direction.
      if (heading != DIR_NONE && heading != last_dir[axis]) begin
         frac_counts[axis] = '0;
         last_dir[axis] = heading;
      end
      acc = int'(frac_counts[axis]) + diff;
      step = acc / span;
      frac_counts[axis] = REM_W'(acc - step * span);
      // The clamp drops whatever exceeds the largest step.
      if (step > int'(mstep_cfg)) step = int'(mstep_cfg);
      if (step < -int'(mstep_cfg)) step = -int'(mstep_cfg);
      return step;
   endfunction

   // Updates the shadow state for one accepted input word and queues its result.
   task automatic predict_word(input logic kind, input logic [COUNT_W-1:0] cx,
                               input logic [COUNT_W-1:0] cy, input logic [TIME_W-1:0] now);
      result_type              want;
      logic [COUNT_W-1:0]      cnt [2];
      logic signed [COUNT_W-1:0] delta;
      int                      stp [2];
      int                      sum;
      int                      a;
      cnt[0] = cx;
      cnt[1] = cy;
      want.report_valid = 1'b0;
      if (kind == KIND_INIT) begin
         // Init latches the counters and recenters without touching the reported copy.
         for (a = 0; a < 2; a++) begin
            last_count[a] = cnt[a];
            joy_pos[a] = '0;
         end
         last_move_ms = now;
      end else begin
         for (a = 0; a < 2; a++) begin
            delta = cnt[a] - last_count[a];
            last_count[a] = cnt[a];
            stp[a] = axis_step(a, int'(delta));
         end
         if (stp[0] != 0 || stp[1] != 0) begin
            for (a = 0; a < 2; a++) begin
               sum = int'(joy_pos[a]) + stp[a];
               if (sum > POS_LIMIT) sum = POS_LIMIT;
               else if (sum < -POS_LIMIT) sum = -POS_LIMIT;
               joy_pos[a] = POS_W'(sum);
            end
            last_move_ms = now;
         end else if ((now - last_move_ms) > TIME_W'(idle_cfg)) begin
            // Idle too long: a displaced stick springs back to the center.
            if (joy_pos[0] != 0 || joy_pos[1] != 0) begin
               joy_pos[0] = '0;
               joy_pos[1] = '0;
               last_move_ms = now;
            end
         end
         if (joy_pos[0] != sent_pos[0] || joy_pos[1] != sent_pos[1]) begin
            want.report_valid = 1'b1;
            sent_pos[0] = joy_pos[0];
            sent_pos[1] = joy_pos[1];
         end
      end
      want.pos_x = joy_pos[0];
      want.pos_y = joy_pos[1];
      position_q.push_back(want);
   endtask

   // Compares one accepted result word with the oldest prediction.
   task automatic compare_word();
      result_type got;
      result_type want;
      got.pos_x = rsp_tdata[7:0];
      got.pos_y = rsp_tdata[15:8];
      got.report_valid = rsp_tuser;
      if (position_q.size() == 0) begin
         report_mismatch("unexpected word", int'(got.pos_x), 0);
      end else begin
         want = position_q.pop_front();
         if (got.pos_x !== want.pos_x)
            report_mismatch("pos_x", int'(got.pos_x), int'(want.pos_x));
         if (got.pos_y !== want.pos_y)
            report_mismatch("pos_y", int'(got.pos_y), int'(want.pos_y));
         if (got.report_valid !== want.report_valid)
            report_mismatch("report_valid", int'(got.report_valid), int'(want.report_valid));
      end
   endtask

   // Watch the three ports at every rising edge.
   always @(posedge clock) begin
      if (reset) begin
         shift_cfg = STEP_SHIFT_RESET;
         mstep_cfg = MAX_STEP_RESET;
         idle_cfg = IDLE_RESET;
         for (int a = 0; a < 2; a++) begin
            last_count[a] = '0;
            joy_pos[a] = '0;
            sent_pos[a] = '0;
            frac_counts[a] = '0;
            last_dir[a] = DIR_NONE;
         end
         last_move_ms = '0;
         position_q.delete();
         pending_words <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_STEP_SHIFT: shift_cfg = csr_wdata[SHIFT_W-1:0];
               REG_MAX_STEP:   mstep_cfg = csr_wdata[MSTEP_W-1:0];
               REG_IDLE:       idle_cfg = csr_wdata[IDLE_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_word(req_tuser, req_tdata[15:0], req_tdata[31:16], req_tdata[63:32]);
         end
         if (rsp_tvalid && rsp_tready) begin
            compare_word();
         end
         pending_words <= position_q.size();
      end
   end

endmodule

// ----- test/tb_encoder_to_joystick_axis.sv -----
// Testbench top for the encoder to joystick axis block: stimulus, flow control and verdict.
module tb_encoder_to_joystick_axis;
   timeunit 1ns;
   timeprecision 1ps;
   import ejx_pkg::*;

   localparam int CLK_HALF         = 4;
   localparam int RESET_CYCLES     = 6;
   localparam int NUM_PHASES       = 7;
   localparam int RANDOM_PER_PHASE = 147;
   localparam int SETTLE_CYCLES    = 8;
   localparam int CYCLE_LIMIT      = 400000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [63:0]           req_tdata = '0;   // counter_x[15:0], counter_y[31:16], time_ms[63:32]
   logic                  req_tuser = 1'b0; // kind[0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;        // pos_x[7:0], pos_y[15:8]
   logic                  rsp_tuser;        // report_valid[0]
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_count;
   int pending_words;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // Last values sent, so that random words move the counters in small, plausible steps.
   logic [COUNT_W-1:0] last_x = '0;
   logic [COUNT_W-1:0] last_y = '0;
   logic [TIME_W-1:0]  last_ms = '0;
   logic               heading [2] = '{1'b0, 1'b0};

   encoder_to_joystick_axis dut (.*);

   ejx_checker checker_inst (.*);

   always #(CLK_HALF) clock = ~clock;

   // The result side stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Offers one word, possibly after a random gap, and waits until it is taken.
   task automatic send_word(input logic kind, input logic [COUNT_W-1:0] cx,
                            input logic [COUNT_W-1:0] cy, input logic [TIME_W-1:0] now);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {now, cy, cx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      last_x = cx;
      last_y = cy;
      last_ms = now;
   endtask

   // Moves one counter mostly in a steady direction, with occasional reversals and jumps.
   function automatic logic [COUNT_W-1:0] next_count(input int axis, input logic [COUNT_W-1:0] prev);
      int r;
      int mag;
      if ($urandom_range(99) < 15) heading[axis] = ~heading[axis];
      r = $urandom_range(99);
      if (r < 20) mag = 0;
      else if (r < 65) mag = $urandom_range(40);
      else if (r < 85) mag = $urandom_range(1200);
      else mag = $urandom_range(32768, 30000);
      if (r >= 93) begin
         next_count = COUNT_W'($urandom);
      end else begin
         next_count = heading[axis] ? prev - COUNT_W'(mag) : prev + COUNT_W'(mag);
      end
   endfunction

   // One random word: mostly updates with a slowly advancing clock, a few inits and jumps.
   task automatic send_random();
      logic              kind;
      logic [TIME_W-1:0] now;
      int                r;
      kind = ($urandom_range(99) < 4) ? KIND_INIT : KIND_UPDATE;
      r = $urandom_range(99);
      if (r < 85) now = last_ms + TIME_W'($urandom_range(40));
      else if (r < 97) now = last_ms + TIME_W'($urandom_range(70000));
      else now = $urandom;
      send_word(kind, next_count(0, last_x), next_count(1, last_y), now);
   endtask

   // Writes all three registers on consecutive edges, with junk above the step-shift and max-step fields.
   task automatic write_settings(input int shift_val, input int mstep_val, input int idle_val);
      csr_we <= 1'b1;
      csr_index <= REG_STEP_SHIFT;
      csr_wdata <= {12'($urandom), 4'(shift_val)};
      @(posedge clock);
      csr_index <= REG_MAX_STEP;
      csr_wdata <= {9'($urandom), 7'(mstep_val)};
      @(posedge clock);
      csr_index <= REG_IDLE;
      csr_wdata <= 16'(idle_val);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Waits until every predicted word has come back, then lets the pipeline settle.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register settings and idling mix of each phase; phase 0 runs on reset values.
   task automatic start_phase(input int ph);
      case (ph)
         1: write_settings(0, 127, 65535);
         2: write_settings(8, 1, 0);
         3: write_settings(15, 0, 20);
         4: write_settings(2, 5, 50);
         5: write_settings(9, 127, 0);
         6: write_settings(6, 64, 1000);
         default: ;
      endcase
      if (ph < 2) begin
         send_idle_pct = 13;
         recv_idle_pct = 82;
      end else if (ph < 4) begin
         send_idle_pct = 82;
         recv_idle_pct = 13;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   initial begin
      int ph;
      int i;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      start_phase(0);

      // Directed words on reset settings: counter wrap, largest differences both ways,
      // reversal, the idle boundary, init with a stale report and position saturation.
      send_word(KIND_INIT,   16'h0000, 16'h0000, 32'd0);
      send_word(KIND_UPDATE, 16'h0010, 16'hFFF0, 32'd5);
      send_word(KIND_UPDATE, 16'h8010, 16'h7FF0, 32'd6);
      send_word(KIND_UPDATE, 16'h000F, 16'hFFFF, 32'd7);
      send_word(KIND_UPDATE, 16'h0014, 16'hFFFF, 32'd8);
      send_word(KIND_UPDATE, 16'h0011, 16'hFFFF, 32'd9);
      send_word(KIND_UPDATE, 16'h0111, 16'hFFFF, 32'd1000);
      send_word(KIND_UPDATE, 16'h0111, 16'hFFFF, 32'd1100);
      send_word(KIND_UPDATE, 16'h0111, 16'hFFFF, 32'd1101);
      send_word(KIND_UPDATE, 16'h0311, 16'hFFFF, 32'd1102);
      send_word(KIND_INIT,   16'h0311, 16'hFFFF, 32'hFFFF_FFF0);
      send_word(KIND_UPDATE, 16'h0311, 16'hFFFF, 32'hFFFF_FFF8);
      for (i = 0; i < 16; i++) begin
         send_word(KIND_UPDATE, last_x + 16'h7FFF, last_y - 16'h7FFF,
                   32'hFFFF_FFFB + 32'(4 * i));
      end

      // Random words under each register setting.
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph != 0) begin
            drain_results();
            start_phase(ph);
         end
         repeat (RANDOM_PER_PHASE) send_random();
      end

      drain_results();
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
